// ===== design/aesbc_pkg.sv =====
// ---------------------------------------------------------------------------
// aesbc_pkg
// Shared types, constants and byte-level functions for the AES block cipher:
// s-box tables, GF(2^8) helpers and the column mixing functions.
// ---------------------------------------------------------------------------
package aesbc_pkg;

  localparam int ROW_W  = 4;
  localparam int WIDX_W = 6;
  localparam int NR_W   = 4;

  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_W0   = 3'd1;
  localparam logic [2:0] CFG_KEY_W1   = 3'd2;
  localparam logic [2:0] CFG_KEY_W2   = 3'd3;
  localparam logic [2:0] CFG_KEY_W3   = 3'd4;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  localparam logic [0:0] FUNC_DEC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND
  } ctl_state_t;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_ENC,
    KX_DEC
  } kx_state_t;

  typedef struct packed {
    logic             start;
    logic             rd_dec;
    logic [ROW_W-1:0] rd_addr;
  } kx_ctrl_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NR_W-1:0] nr;
  } kx_stat_t;

  localparam logic [2047:0] FWD_BOX = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_BOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] fwd_sb(input logic [7:0] x);
    return FWD_BOX[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sb(input logic [7:0] x);
    return INV_BOX[{~x, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {fwd_sb(w[31:24]), fwd_sb(w[23:16]), fwd_sb(w[15:8]), fwd_sb(w[7:0])};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // forward column: 2 3 1 1
  function automatic logic [31:0] mix_fwd(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] d [4];
    a[0] = w[31:24];
    a[1] = w[23:16];
    a[2] = w[15:8];
    a[3] = w[7:0];
    for (int k = 0; k < 4; k++) begin
      d[k] = xt(a[k]);
    end
    return {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
            a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
            a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3],
            d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};
  endfunction

  // inverse column: e b d 9
  function automatic logic [31:0] mix_inv(input logic [31:0] w);
    logic [7:0] a  [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] me [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] m9 [4];
    a[0] = w[31:24];
    a[1] = w[23:16];
    a[2] = w[15:8];
    a[3] = w[7:0];
    for (int k = 0; k < 4; k++) begin
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      me[k] = x8[k] ^ x4[k] ^ x2[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

// ===== design/aes_block_cipher.sv =====
// ---------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 ECB encrypt and decrypt with an iterative round unit.
// ---------------------------------------------------------------------------
// A block is taken when start is high and busy is low; busy then stays high
// until the result, which appears for one cycle with out_valid and cannot be
// stalled. A block passes the load state, then the round state with the
// single round unit doing one round per cycle on round keys read a row at a
// time from the key store. The first block after reset or a key register
// write first expands the encryption, then the decryption keys. Registers
// are to be written only while busy is low; the block does not enforce it.
module aes_block_cipher #(
  parameter int ROUND_KEY_WORDS = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aesbc_pkg::*;

  ctl_state_t       st_r, st_nxt;
  logic [1:0]       key_size_r;
  logic [255:0]     key_r;
  logic             sched_ok_r, sched_ok_nxt;
  logic             dec_r;
  logic [127:0]     blk_r, blk_nxt;
  logic [NR_W-1:0]  rnd_r, rnd_nxt;
  logic             out_valid_r, out_valid_nxt;

  kx_ctrl_t         kx_ctrl;
  kx_stat_t         kx_stat;
  logic [127:0]     rkey;
  logic [127:0]     round_out;
  logic             accept;

  assign accept = start && (st_r == ST_IDLE);

  aesbc_key_sched #(
    .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
  ) u_key_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_size_i (key_size_r),
    .key_i      (key_r),
    .ctrl_i     (kx_ctrl),
    .stat_o     (kx_stat),
    .rkey_o     (rkey)
  );

  aesbc_round_unit u_round (
    .state_i (blk_r),
    .rkey_i  (rkey),
    .dec_i   (dec_r),
    .last_i  (rnd_r == kx_stat.nr),
    .state_o (round_out)
  );

  always_comb begin
    st_nxt          = st_r;
    sched_ok_nxt    = sched_ok_r;
    blk_nxt         = blk_r;
    rnd_nxt         = rnd_r;
    out_valid_nxt   = 1'b0;
    kx_ctrl.start   = 1'b0;
    kx_ctrl.rd_dec  = dec_r;
    kx_ctrl.rd_addr = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          blk_nxt = {in_block_high, in_block_low};
          if (sched_ok_r) begin
            st_nxt = ST_LOAD;
          end else begin
            st_nxt        = ST_EXPAND;
            kx_ctrl.start = 1'b1;
          end
        end
      end
      ST_EXPAND: begin
        if (kx_stat.done) begin
          st_nxt       = ST_LOAD;
          sched_ok_nxt = 1'b1;
        end
      end
      ST_LOAD: begin
        st_nxt  = ST_ROUND;
        rnd_nxt = '0;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + NR_W'(1);
        if (rnd_r == '0) begin
          blk_nxt = blk_r ^ rkey;
        end else begin
          blk_nxt = round_out;
        end
        if (rnd_r == kx_stat.nr) begin
          st_nxt        = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          kx_ctrl.rd_addr = ROW_W'(rnd_r) + ROW_W'(1);
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_wr_en && cfg_index <= CFG_KEY_W3) begin
      sched_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sched_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_size_r  <= '0;
      key_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      sched_ok_r  <= sched_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_KEY_SIZE: key_size_r      <= cfg_data[1:0];
          CFG_KEY_W0:   key_r[255:192]  <= cfg_data;
          CFG_KEY_W1:   key_r[191:128]  <= cfg_data;
          CFG_KEY_W2:   key_r[127:64]   <= cfg_data;
          CFG_KEY_W3:   key_r[63:0]     <= cfg_data;
          default: ;
        endcase
      end
    end
    blk_r <= blk_nxt;
    rnd_r <= rnd_nxt;
    if (accept) begin
      dec_r <= (in_func == FUNC_DEC);
    end
  end

  assign busy            = (st_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_high = blk_r[127:64];
  assign out_result_low  = blk_r[63:0];

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  a_expand_when_stale: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !sched_ok_r |=> st_r == ST_EXPAND)
    else $error("stale schedule not rebuilt");

  a_kx_done_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
    kx_stat.done |-> st_r == ST_EXPAND)
    else $error("key expansion finished outside expand");

  a_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ROUND && rnd_r == kx_stat.nr |=> out_valid)
    else $error("last round gave no result");

endmodule

// ===== design/aesbc_round_unit.sv =====
// ---------------------------------------------------------------------------
// aesbc_round_unit
// One cipher round per use: substitute and shift rows, mix columns unless
// last round, add round key. Forward or equivalent inverse direction.
// ---------------------------------------------------------------------------
module aesbc_round_unit (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         dec_i,
  input  logic         last_i,
  output logic [127:0] state_o
);
  import aesbc_pkg::*;

  logic [7:0]   sb [16];
  logic [7:0]   t  [16];
  logic [127:0] shifted;
  logic [127:0] mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = state_i[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_i) begin
          t[r + 4*c] = inv_sb(sb[r + 4*((c + 4 - r) % 4)]);
        end else begin
          t[r + 4*c] = fwd_sb(sb[r + 4*((c + r) % 4)]);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      shifted[127 - 8*i -: 8] = t[i];
    end
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 32] = dec_i ? mix_inv(shifted[127 - 32*c -: 32])
                                      : mix_fwd(shifted[127 - 32*c -: 32]);
    end
    state_o = (last_i ? shifted : mixed) ^ rkey_i;
  end

endmodule

// ===== design/aesbc_key_sched.sv =====
// ---------------------------------------------------------------------------
// aesbc_key_sched
// Key expansion, one word per cycle, into the encryption round key store,
// then a pass that builds the decryption store a row per cycle. Both stores
// share one registered read port with the round sequencer.
// ---------------------------------------------------------------------------
module aesbc_key_sched #(
  parameter int ROUND_KEY_WORDS = 60
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              key_size_i,
  input  logic [255:0]            key_i,
  input  aesbc_pkg::kx_ctrl_t     ctrl_i,
  output aesbc_pkg::kx_stat_t     stat_o,
  output logic [127:0]            rkey_o
);
  import aesbc_pkg::*;

  localparam int ROWS   = ROUND_KEY_WORDS / 4;
  localparam int NK_MAX = (ROUND_KEY_WORDS >= 60) ? 8 : (ROUND_KEY_WORDS >= 52) ? 6 : 4;

  logic [127:0] enc_mem [ROWS];
  logic [127:0] dec_mem [ROWS];

  kx_state_t          st_r, st_nxt;
  logic [WIDX_W-1:0]  i_r, i_nxt;
  logic [2:0]         mod_r, mod_nxt;
  logic [3:0]         nk_r, nk_nxt;
  logic [NR_W-1:0]    nr_r, nr_nxt;
  logic [7:0]         rc_r, rc_nxt;
  logic [31:0]        win_r [8];
  logic [95:0]        acc_r;
  logic [ROW_W-1:0]   j_r, j_nxt;
  logic [127:0]       rkey_r;

  logic [3:0]         nk_sel;
  logic [31:0]        w_new;
  logic [31:0]        t_w;
  logic [31:0]        far_w;
  logic [WIDX_W-1:0]  total_m1;
  logic               enc_we;
  logic               dec_we;
  logic [ROW_W-1:0]   dec_waddr;
  logic [127:0]       dec_wdata;
  logic               rd_dec;
  logic [ROW_W-1:0]   rd_addr;
  logic               done;

  always_comb begin
    unique case (key_size_i)
      KS_128:  nk_sel = 4'd4;
      KS_192:  nk_sel = 4'd6;
      default: nk_sel = 4'd8;
    endcase
    if (nk_sel > 4'(NK_MAX)) begin
      nk_sel = 4'(NK_MAX);
    end
  end

  always_comb begin
    unique case (nk_r)
      4'd4:    far_w = win_r[3];
      4'd6:    far_w = win_r[5];
      default: far_w = win_r[7];
    endcase
    t_w = win_r[0];
    if (mod_r == 3'd0) begin
      t_w = subst_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'h0};
    end else if (nk_r == 4'd8 && mod_r == 3'd4) begin
      t_w = subst_word(win_r[0]);
    end
    if (i_r < WIDX_W'(nk_r)) begin
      w_new = key_i[255 - 32*i_r[2:0] -: 32];
    end else begin
      w_new = far_w ^ t_w;
    end
  end

  assign total_m1 = WIDX_W'({nr_r, 2'b00}) + WIDX_W'(3);

  always_comb begin
    st_nxt    = st_r;
    i_nxt     = i_r;
    mod_nxt   = mod_r;
    nk_nxt    = nk_r;
    nr_nxt    = nr_r;
    rc_nxt    = rc_r;
    j_nxt     = j_r;
    enc_we    = 1'b0;
    dec_we    = 1'b0;
    done      = 1'b0;
    rd_dec    = ctrl_i.rd_dec;
    rd_addr   = ctrl_i.rd_addr;
    dec_waddr = nr_r - (j_r - ROW_W'(1));
    if (j_r == ROW_W'(1) || j_r == ROW_W'(nr_r) + ROW_W'(1)) begin
      dec_wdata = rkey_r;
    end else begin
      dec_wdata = {mix_inv(rkey_r[127:96]), mix_inv(rkey_r[95:64]),
                   mix_inv(rkey_r[63:32]), mix_inv(rkey_r[31:0])};
    end
    unique case (st_r)
      KX_IDLE: begin
        if (ctrl_i.start) begin
          st_nxt  = KX_ENC;
          i_nxt   = '0;
          mod_nxt = '0;
          nk_nxt  = nk_sel;
          nr_nxt  = NR_W'(nk_sel + 4'd6);
          rc_nxt  = RCON_INIT;
        end
      end
      KX_ENC: begin
        i_nxt   = i_r + WIDX_W'(1);
        mod_nxt = (mod_r == 3'(nk_r - 4'd1)) ? 3'd0 : mod_r + 3'd1;
        if (i_r >= WIDX_W'(nk_r) && mod_r == 3'd0) begin
          rc_nxt = xt(rc_r);
        end
        enc_we = (i_r[1:0] == 2'd3);
        if (i_r == total_m1) begin
          st_nxt = KX_DEC;
          j_nxt  = '0;
        end
      end
      KX_DEC: begin
        rd_dec  = 1'b0;
        rd_addr = (j_r <= ROW_W'(nr_r)) ? j_r : '0;
        j_nxt   = j_r + ROW_W'(1);
        dec_we  = (j_r != '0);
        if (j_r == ROW_W'(nr_r) + ROW_W'(1)) begin
          st_nxt = KX_IDLE;
          done   = 1'b1;
        end
      end
      default: st_nxt = KX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= KX_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    i_r   <= i_nxt;
    mod_r <= mod_nxt;
    nk_r  <= nk_nxt;
    nr_r  <= nr_nxt;
    rc_r  <= rc_nxt;
    j_r   <= j_nxt;
    if (st_r == KX_ENC) begin
      win_r[0] <= w_new;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
      acc_r <= {acc_r[63:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (enc_we) begin
      enc_mem[i_r[ROW_W+1:2]] <= {acc_r, w_new};
    end
    if (dec_we) begin
      dec_mem[dec_waddr] <= dec_wdata;
    end
    rkey_r <= rd_dec ? dec_mem[rd_addr] : enc_mem[rd_addr];
  end

  assign rkey_o      = rkey_r;
  assign stat_o.busy = (st_r != KX_IDLE);
  assign stat_o.done = done;
  assign stat_o.nr   = nr_r;

endmodule

// ===== dv/aes_block_cipher_tb.sv =====
// ---------------------------------------------------------------------------
// aes_block_cipher_tb
// Self-checking bench for the AES block cipher. A directed table covers the
// standard key sizes with known vectors, key size code three and extreme
// blocks. Random phases under new keys and varied sender idling follow. Each
// result word is checked against an in-bench AES model with its own schedule.
// ---------------------------------------------------------------------------
module aes_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aesbc_pkg::*;

  localparam logic [1:0] KS_256    = 2'd2;
  localparam logic [1:0] KS_CODE3  = 2'd3;
  localparam logic [0:0] FUNC_ENC  = ~FUNC_DEC;
  localparam int         RUN_LIMIT = 400000;
  localparam int         N_PHASES  = 12;
  localparam int         PHASE_LEN = 120;

  typedef enum logic { ROW_KEY, ROW_BLOCK } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  sel;
    logic [63:0] d [4];
    bit          has_exp;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        out_valid;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_block_cipher i_dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_block_high, .in_block_low,
    .out_valid, .out_result_high, .out_result_low, .cfg_wr_en, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0]   sbox [256];
  logic [7:0]   inv_sbox [256];
  logic [1:0]   key_sz;
  logic [63:0]  key_w [4];
  logic [31:0]  enc_rk [60];
  logic [31:0]  dec_rk [60];
  bit           sched_ok;
  int           n_rounds;
  logic [127:0] pending_words [$];
  int           errors;
  int           cycles;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    while (b != 0) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b >>= 1;
    end
    return p;
  endfunction

  function automatic void build_sboxes();
    logic [7:0] b, s;
    for (int x = 0; x < 256; x++) begin
      b = (x == 0) ? 8'h00 : 8'h01;
      if (x != 0) for (int k = 0; k < 254; k++) b = gmul(b, x[7:0]);
      s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
      sbox[x] = s;
      inv_sbox[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_word(logic [31:0] w, logic [7:0] m0, logic [7:0] m1,
                                           logic [7:0] m2, logic [7:0] m3);
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = w;
    return {gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3),
            gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2),
            gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1),
            gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0)};
  endfunction

  function automatic void expand_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = (key_sz == KS_128) ? 4 : (key_sz == KS_192) ? 6 : 8;
    n_rounds = nk + 6;
    total = 4 * (n_rounds + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) enc_rk[i] = i[0] ? key_w[i/2][31:0] : key_w[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = enc_rk[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      enc_rk[i] = enc_rk[i-nk] ^ t;
    end
    for (int j = 0; j < 4; j++) begin
      dec_rk[j] = enc_rk[n_rounds*4 + j];
      dec_rk[n_rounds*4 + j] = enc_rk[j];
    end
    for (int i = 1; i < n_rounds; i++)
      for (int j = 0; j < 4; j++)
        dec_rk[(n_rounds-i)*4 + j] = mix_word(enc_rk[i*4 + j], 8'h0e, 8'h0b, 8'h0d, 8'h09);
    sched_ok = 1'b1;
  endfunction

  function automatic logic [127:0] cipher_block(logic dec, logic [63:0] hi, logic [63:0] lo);
    logic [127:0] st, tmp;
    logic [7:0] v;
    int src;
    if (!sched_ok) expand_schedule();
    st = {hi, lo};
    for (int r = 0; r <= n_rounds; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) begin
            src = dec ? ((c + 4 - w) % 4) : ((c + w) % 4);
            v = st[127 - 8*(w + 4*src) -: 8];
            tmp[127 - 8*(w + 4*c) -: 8] = dec ? inv_sbox[v] : sbox[v];
          end
        st = tmp;
        if (r < n_rounds)
          for (int c = 0; c < 4; c++)
            st[127 - 32*c -: 32] = dec ? mix_word(st[127 - 32*c -: 32], 8'h0e, 8'h0b, 8'h0d, 8'h09)
                                       : mix_word(st[127 - 32*c -: 32], 8'h02, 8'h03, 8'h01, 8'h01);
      end
      for (int c = 0; c < 4; c++)
        st[127 - 32*c -: 32] ^= dec ? dec_rk[4*r + c] : enc_rk[4*r + c];
    end
    return st;
  endfunction

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && start && !busy)
      pending_words.push_back(cipher_block(in_func, in_block_high, in_block_low));
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h %h", $realtime, out_result_high, out_result_low);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_result_high !== want[127:64]) begin
          $display("%0t: result_high expected %h actual %h", $realtime, want[127:64],
                   out_result_high);
          errors++;
        end
        if (out_result_low !== want[63:0]) begin
          $display("%0t: result_low expected %h actual %h", $realtime, want[63:0],
                   out_result_low);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("aes_block_cipher_tb: FAIL");
      $finish;
    end
  end

  task automatic send_block(logic f, logic [63:0] hi, logic [63:0] lo);
    start <= 1'b1;
    in_func <= f;
    in_block_high <= hi;
    in_block_low <= lo;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_KEY_SIZE) key_sz = val[1:0];
    else if (idx <= CFG_KEY_W3) key_w[idx - 1] = val;
    if (idx <= CFG_KEY_W3) sched_ok = 1'b0;
  endtask

  task automatic load_key(logic [1:0] ks, logic [63:0] w0, logic [63:0] w1,
                          logic [63:0] w2, logic [63:0] w3);
    drain();
    write_reg(CFG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | ks);
    write_reg(CFG_KEY_W0, w0);
    write_reg(CFG_KEY_W1, w1);
    write_reg(CFG_KEY_W2, w2);
    write_reg(CFG_KEY_W3, w3);
    write_reg(3'($urandom_range(CFG_KEY_W3 + 1, 7)), {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_field();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  stim_row_t dir_rows [] = '{
    '{ROW_BLOCK, FUNC_ENC, '{64'h0, 64'h0, 0, 0}, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{ROW_BLOCK, FUNC_DEC, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 0, 0}, 1, 64'h0, 64'h0},
    '{ROW_BLOCK, FUNC_ENC, '{'1, '1, 0, 0}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_DEC, '{'1, '1, 0, 0}, 0, 0, 0},
    '{ROW_KEY, KS_128, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_ENC, '{64'h0011223344556677, 64'h8899aabbccddeeff, 0, 0}, 1,
      64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
    '{ROW_BLOCK, FUNC_DEC, '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0, 0}, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    '{ROW_KEY, KS_192, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
      '1}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_ENC, '{64'h0011223344556677, 64'h8899aabbccddeeff, 0, 0}, 1,
      64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
    '{ROW_BLOCK, FUNC_DEC, '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 0, 0}, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    '{ROW_KEY, KS_256, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
      64'h18191a1b1c1d1e1f}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_ENC, '{64'h0011223344556677, 64'h8899aabbccddeeff, 0, 0}, 1,
      64'h8ea2b7ca516745bf, 64'heafc49904b496089},
    '{ROW_BLOCK, FUNC_DEC, '{64'h8ea2b7ca516745bf, 64'heafc49904b496089, 0, 0}, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    // key size code three acts as a 256-bit key
    '{ROW_KEY, KS_CODE3, '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
      64'h18191a1b1c1d1e1f}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_ENC, '{64'h0011223344556677, 64'h8899aabbccddeeff, 0, 0}, 1,
      64'h8ea2b7ca516745bf, 64'heafc49904b496089},
    '{ROW_BLOCK, FUNC_ENC, '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, 0}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_DEC, '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, 0}, 0, 0, 0},
    '{ROW_KEY, KS_256, '{'1, '1, '1, '1}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_ENC, '{'0, '1, 0, 0}, 0, 0, 0},
    '{ROW_BLOCK, FUNC_DEC, '{'1, '0, 0, 0}, 0, 0, 0}
  };

  initial begin
    logic [127:0] got;
    int idle_pct;
    build_sboxes();
    key_sz = KS_128;
    foreach (key_w[i]) key_w[i] = '0;
    sched_ok = 1'b0;
    errors = 0;
    cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_KEY) begin
        load_key(dir_rows[i].sel, dir_rows[i].d[0], dir_rows[i].d[1], dir_rows[i].d[2],
                 dir_rows[i].d[3]);
      end else begin
        if (dir_rows[i].has_exp) begin
          got = cipher_block(dir_rows[i].sel[0], dir_rows[i].d[0], dir_rows[i].d[1]);
          if (got !== {dir_rows[i].exp_hi, dir_rows[i].exp_lo}) begin
            $display("%0t: known vector expected %h %h actual %h", $realtime,
                     dir_rows[i].exp_hi, dir_rows[i].exp_lo, got);
            errors++;
          end
        end
        send_block(dir_rows[i].sel[0], dir_rows[i].d[0], dir_rows[i].d[1]);
        pause($urandom_range(0, 2));
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: load_key(KS_128, '0, '0, '0, '0);
        1: load_key(KS_256, '1, '1, '1, '1);
        2: load_key(KS_CODE3, rand_field(), rand_field(), rand_field(), rand_field());
        default: load_key(2'($urandom_range(0, 3)), rand_field(), rand_field(), rand_field(),
                          rand_field());
      endcase
      idle_pct = (p % 4 == 0) ? 0 : (p % 4 == 3) ? 14 : 66;
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_block(1'($urandom), rand_field(), rand_field());
        if ($urandom_range(1, 100) <= idle_pct) pause($urandom_range(1, 20));
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("aes_block_cipher_tb: PASS");
    else $display("aes_block_cipher_tb: FAIL");
    $finish;
  end

endmodule
